### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// consequence checked in the cycle after the trigger
`define ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/ihd_pkg.sv
// types and constants of the indexed min-heap
package ihd_pkg;

  localparam int IHD_ENTRIES  = 256;
  localparam int IHD_KEY_BITS = 32;
  localparam int LABELS       = 256;
  localparam int LABEL_W      = 8;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_EXTRACT  = 2'd2;
  localparam logic [1:0] OP_DECREASE = 2'd3;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  entry_label;
    logic [31:0] entry_key;
    logic [31:0] entry_dist;
  } ihd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_label;
    logic [31:0] out_key;
    logic [31:0] out_dist;
    logic [8:0]  entry_count;
  } ihd_rsp_t;

  typedef struct packed {
    logic slot_we;
    logic data_we;
  } ihd_lm_we_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_XDIST,
    ST_XLAST,
    ST_UP,
    ST_UPC,
    ST_DN,
    ST_DNC
  } ihd_state_e;

endpackage

### src/ihd_slot_mem.sv
// slot memory: label and key per heap slot, one write and two read ports
module ihd_slot_mem #(
  parameter int ENTRIES  = ihd_pkg::IHD_ENTRIES,
  parameter int KEY_BITS = ihd_pkg::IHD_KEY_BITS
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [ihd_pkg::LABEL_W-1:0] wlabel_i,
  input  logic [KEY_BITS-1:0]        wkey_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_a_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_b_i,
  output logic [ihd_pkg::LABEL_W-1:0] rlabel_a_o,
  output logic [KEY_BITS-1:0]        rkey_a_o,
  output logic [ihd_pkg::LABEL_W-1:0] rlabel_b_o,
  output logic [KEY_BITS-1:0]        rkey_b_o
);
  import ihd_pkg::*;

  localparam int DW = LABEL_W + KEY_BITS;

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rd_a_q;
  logic [DW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wlabel_i, wkey_i};
    end
    rd_a_q <= mem[raddr_a_i];
    rd_b_q <= mem[raddr_b_i];
  end

  assign rlabel_a_o = rd_a_q[DW-1:KEY_BITS];
  assign rkey_a_o   = rd_a_q[KEY_BITS-1:0];
  assign rlabel_b_o = rd_b_q[DW-1:KEY_BITS];
  assign rkey_b_o   = rd_b_q[KEY_BITS-1:0];

endmodule

### src/ihd_label_mem.sv
// label memory: slot, key and distance per label with field write enables
module ihd_label_mem #(
  parameter int ENTRIES  = ihd_pkg::IHD_ENTRIES,
  parameter int KEY_BITS = ihd_pkg::IHD_KEY_BITS
) (
  input  logic                        clk_i,
  input  ihd_pkg::ihd_lm_we_t         we_i,
  input  logic [ihd_pkg::LABEL_W-1:0] waddr_i,
  input  logic [$clog2(ENTRIES)-1:0]  wslot_i,
  input  logic [KEY_BITS-1:0]         wkey_i,
  input  logic [31:0]                 wdist_i,
  input  logic [ihd_pkg::LABEL_W-1:0] raddr_i,
  output logic [$clog2(ENTRIES)-1:0]  rslot_o,
  output logic [KEY_BITS-1:0]         rkey_o,
  output logic [31:0]                 rdist_o
);
  import ihd_pkg::*;

  localparam int SW = $clog2(ENTRIES);

  logic [SW-1:0]       slot_mem [LABELS];
  logic [KEY_BITS-1:0] key_mem  [LABELS];
  logic [31:0]         dist_mem [LABELS];

  always_ff @(posedge clk_i) begin
    if (we_i.slot_we) begin
      slot_mem[waddr_i] <= wslot_i;
    end
    if (we_i.data_we) begin
      key_mem[waddr_i]  <= wkey_i;
      dist_mem[waddr_i] <= wdist_i;
    end
    rslot_o <= slot_mem[raddr_i];
    rkey_o  <= key_mem[raddr_i];
    rdist_o <= dist_mem[raddr_i];
  end

endmodule

### src/indexed_min_heap_decrease_key.sv
// indexed binary min-heap with decrease-key, sequenced over two memories
// clear completes from idle; append and decrease pass the check state, then sift up;
// extract reads top, distance and last entry, then sifts down, unless the heap empties;
// refusals and empty extract end at check; busy_o is high until the result strobe cycle
// sift up: one slot read and compare per step; sift down: two of each; result never stalled
// reset clears the entry count and presence bits at once; no memory sweep is needed
`include "assert_macros.svh"

module indexed_min_heap_decrease_key #(
  parameter int ENTRIES  = ihd_pkg::IHD_ENTRIES,
  parameter int KEY_BITS = ihd_pkg::IHD_KEY_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ihd_pkg::ihd_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output ihd_pkg::ihd_rsp_t rsp_o
);
  import ihd_pkg::*;

  localparam int SW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int CXW = SW + 2;

  ihd_state_e          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [LABEL_W-1:0]  lab_q, lab_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [31:0]         dist_q, dist_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic [LABEL_W-1:0]  mv_lab_q, mv_lab_d;
  logic [KEY_BITS-1:0] mv_key_q, mv_key_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [LABELS-1:0]   present_q, present_d;
  ihd_rsp_t            rsp_q, rsp_d;
  logic                done_q, done_d;

  logic                sm_we;
  logic [SW-1:0]       sm_waddr;
  logic [LABEL_W-1:0]  sm_wlabel;
  logic [KEY_BITS-1:0] sm_wkey;
  logic [SW-1:0]       sm_raddr_a, sm_raddr_b;
  logic [LABEL_W-1:0]  sm_rlabel_a, sm_rlabel_b;
  logic [KEY_BITS-1:0] sm_rkey_a, sm_rkey_b;

  ihd_lm_we_t          lm_we;
  logic [LABEL_W-1:0]  lm_waddr;
  logic [SW-1:0]       lm_wslot;
  logic [KEY_BITS-1:0] lm_wkey;
  logic [31:0]         lm_wdist;
  logic [LABEL_W-1:0]  lm_raddr;
  logic [SW-1:0]       lm_rslot;
  logic [KEY_BITS-1:0] lm_rkey;
  logic [31:0]         lm_rdist;

  logic                accept;
  logic                in_range, pres, full;
  logic [CXW-1:0]      child, child_r, cnt_x, pick_idx;
  logic                take_right;
  logic [LABEL_W-1:0]  pick_lab;
  logic [KEY_BITS-1:0] pick_key;

  ihd_slot_mem #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_slot_mem (
    .clk_i      (clk_i),
    .we_i       (sm_we),
    .waddr_i    (sm_waddr),
    .wlabel_i   (sm_wlabel),
    .wkey_i     (sm_wkey),
    .raddr_a_i  (sm_raddr_a),
    .raddr_b_i  (sm_raddr_b),
    .rlabel_a_o (sm_rlabel_a),
    .rkey_a_o   (sm_rkey_a),
    .rlabel_b_o (sm_rlabel_b),
    .rkey_b_o   (sm_rkey_b)
  );

  ihd_label_mem #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_label_mem (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (lm_waddr),
    .wslot_i (lm_wslot),
    .wkey_i  (lm_wkey),
    .wdist_i (lm_wdist),
    .raddr_i (lm_raddr),
    .rslot_o (lm_rslot),
    .rkey_o  (lm_rkey),
    .rdist_o (lm_rdist)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign in_range   = (32'(lab_q) < 32'(ENTRIES));
  assign pres       = in_range && present_q[lab_q];
  assign full       = (32'(cnt_q) >= 32'(ENTRIES));
  assign cnt_x      = CXW'(cnt_q);
  assign child      = CXW'({idx_q, 1'b1});
  assign child_r    = child + CXW'(1);
  assign take_right = (child_r < cnt_x) && (sm_rkey_b < sm_rkey_a);
  assign pick_lab   = take_right ? sm_rlabel_b : sm_rlabel_a;
  assign pick_key   = take_right ? sm_rkey_b : sm_rkey_a;
  assign pick_idx   = take_right ? child_r : child;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    lab_d     = lab_q;
    key_d     = key_q;
    dist_d    = dist_q;
    idx_d     = idx_q;
    mv_lab_d  = mv_lab_q;
    mv_key_d  = mv_key_q;
    cnt_d     = cnt_q;
    present_d = present_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    sm_we      = 1'b0;
    sm_waddr   = idx_q;
    sm_wlabel  = mv_lab_q;
    sm_wkey    = mv_key_q;
    sm_raddr_a = '0;
    sm_raddr_b = '0;
    lm_we      = '0;
    lm_waddr   = mv_lab_q;
    lm_wslot   = idx_q;
    lm_wkey    = key_q;
    lm_wdist   = dist_q;
    lm_raddr   = req_i.entry_label;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = req_i.opcode;
          lab_d  = req_i.entry_label;
          key_d  = KEY_BITS'(req_i.entry_key);
          dist_d = req_i.entry_dist;
          if (req_i.opcode == OP_CLEAR) begin
            cnt_d     = '0;
            present_d = '0;
            rsp_d     = '0;
            done_d    = 1'b1;
          end else begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        rsp_d.out_label   = lab_q;
        rsp_d.out_key     = pres ? 32'(lm_rkey) : 32'd0;
        rsp_d.out_dist    = pres ? lm_rdist : 32'd0;
        rsp_d.entry_count = 9'(cnt_q);
        rsp_d.status      = STAT_REFUSED;
        mv_lab_d          = lab_q;
        mv_key_d          = key_q;
        case (op_q)
          OP_APPEND: begin
            if (!in_range || pres || full) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              lm_we.slot_we     = 1'b1;
              lm_we.data_we     = 1'b1;
              lm_waddr          = lab_q;
              lm_wslot          = SW'(cnt_q);
              present_d[lab_q]  = 1'b1;
              cnt_d             = cnt_q + CW'(1);
              idx_d             = SW'(cnt_q);
              rsp_d.status      = STAT_DONE;
              rsp_d.out_key     = 32'(key_q);
              rsp_d.out_dist    = dist_q;
              rsp_d.entry_count = 9'(cnt_q + CW'(1));
              state_d           = ST_UP;
            end
          end
          OP_DECREASE: begin
            if (!pres || (key_q > lm_rkey)) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              lm_we.data_we  = 1'b1;
              lm_waddr       = lab_q;
              idx_d          = lm_rslot;
              rsp_d.status   = STAT_DONE;
              rsp_d.out_key  = 32'(key_q);
              rsp_d.out_dist = dist_q;
              state_d        = ST_UP;
            end
          end
          default: begin
            if (cnt_q == '0) begin
              rsp_d   = '0;
              rsp_d.status = STAT_EMPTY;
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              lm_raddr                = sm_rlabel_a;
              present_d[sm_rlabel_a]  = 1'b0;
              cnt_d                   = cnt_q - CW'(1);
              rsp_d.status            = STAT_DONE;
              rsp_d.out_label         = sm_rlabel_a;
              rsp_d.out_key           = 32'(sm_rkey_a);
              rsp_d.entry_count       = 9'(cnt_q - CW'(1));
              state_d                 = ST_XDIST;
            end
          end
        endcase
      end
      ST_XDIST: begin
        rsp_d.out_dist = lm_rdist;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          sm_raddr_a = SW'(cnt_q);
          state_d    = ST_XLAST;
        end
      end
      ST_XLAST: begin
        mv_lab_d = sm_rlabel_a;
        mv_key_d = sm_rkey_a;
        idx_d    = '0;
        state_d  = ST_DN;
      end
      ST_UP: begin
        if (idx_q == '0) begin
          sm_we         = 1'b1;
          lm_we.slot_we = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          sm_raddr_a = (idx_q - SW'(1)) >> 1;
          state_d    = ST_UPC;
        end
      end
      ST_UPC: begin
        sm_we         = 1'b1;
        lm_we.slot_we = 1'b1;
        if (sm_rkey_a > mv_key_q) begin
          sm_wlabel = sm_rlabel_a;
          sm_wkey   = sm_rkey_a;
          lm_waddr  = sm_rlabel_a;
          idx_d     = (idx_q - SW'(1)) >> 1;
          state_d   = ST_UP;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DN: begin
        if (child >= cnt_x) begin
          sm_we         = 1'b1;
          lm_we.slot_we = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          sm_raddr_a = SW'(child);
          sm_raddr_b = SW'(child_r);
          state_d    = ST_DNC;
        end
      end
      ST_DNC: begin
        sm_we         = 1'b1;
        lm_we.slot_we = 1'b1;
        if (pick_key < mv_key_q) begin
          sm_wlabel = pick_lab;
          sm_wkey   = pick_key;
          lm_waddr  = pick_lab;
          idx_d     = SW'(pick_idx);
          state_d   = ST_DN;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      present_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      present_q <= present_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    lab_q    <= lab_d;
    key_q    <= key_d;
    dist_q   <= dist_d;
    idx_q    <= idx_d;
    mv_lab_q <= mv_lab_d;
    mv_key_q <= mv_key_d;
    rsp_q    <= rsp_d;
  end

  `ASSERT_ALWAYS(a_done_idle, done_o |-> !busy_o)
  `ASSERT_ALWAYS(a_cnt_range, 32'(cnt_q) <= 32'(ENTRIES))
  `ASSERT_NEXT(a_clear_done, accept && (req_i.opcode == OP_CLEAR), done_o && (cnt_q == '0))

endmodule

### tb/sv/tb.sv
// self-checking testbench for the indexed min-heap with decrease-key
module tb;
  import ihd_pkg::*;

  typedef struct {
    ihd_req_t req;
    int       gap;
    bit       drain;
  } heap_cmd_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  ihd_req_t req_i;
  logic     busy_o;
  logic     done_o;
  ihd_rsp_t rsp_o;

  indexed_min_heap_decrease_key dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  heap_cmd_t cmd_q[$];
  ihd_rsp_t  rsp_q[$];
  int        errors;
  int        n_sent, n_done, n_empty, n_refused, n_deep;
  bit        took;
  int        gap_left;

  // shadow heap
  logic [7:0]  sh_slot_label[256];
  logic [7:0]  sh_label_slot[256];
  bit          sh_present[256];
  logic [31:0] sh_key[256];
  logic [31:0] sh_dist[256];
  int          sh_count;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void place(int s, logic [7:0] lab);
    sh_slot_label[s] = lab;
    sh_label_slot[lab] = s[7:0];
  endfunction

  function automatic void bubble_up(logic [7:0] lab);
    int i;
    int p;
    i = sh_label_slot[lab];
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(sh_key[sh_slot_label[p]] > sh_key[lab])) break;
      place(i, sh_slot_label[p]);
      i = p;
    end
    place(i, lab);
  endfunction

  function automatic void bubble_down();
    logic [7:0] lab;
    int i;
    int c;
    lab = sh_slot_label[0];
    i = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= sh_count) break;
      if (c + 1 < sh_count && sh_key[sh_slot_label[c+1]] < sh_key[sh_slot_label[c]]) c++;
      if (!(sh_key[sh_slot_label[c]] < sh_key[lab])) break;
      place(i, sh_slot_label[c]);
      i = c;
    end
    if (i > 2) n_deep++;
    place(i, lab);
  endfunction

  function automatic ihd_rsp_t heap_predict(ihd_req_t r);
    ihd_rsp_t   o;
    logic [7:0] lab;
    logic [7:0] top;
    lab = r.entry_label;
    o = '0;
    case (r.opcode)
      OP_CLEAR: begin
        sh_count = 0;
        foreach (sh_present[j]) sh_present[j] = 1'b0;
      end
      OP_APPEND: begin
        o.out_label = lab;
        if (sh_present[lab] || sh_count >= IHD_ENTRIES) begin
          o.status = STAT_REFUSED;
          if (sh_present[lab]) begin
            o.out_key  = sh_key[lab];
            o.out_dist = sh_dist[lab];
          end
        end else begin
          sh_key[lab] = r.entry_key;
          sh_dist[lab] = r.entry_dist;
          sh_present[lab] = 1'b1;
          place(sh_count, lab);
          sh_count++;
          bubble_up(lab);
          o.out_key  = r.entry_key;
          o.out_dist = r.entry_dist;
        end
      end
      OP_EXTRACT: begin
        if (sh_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          top = sh_slot_label[0];
          o.out_label = top;
          o.out_key = sh_key[top];
          o.out_dist = sh_dist[top];
          sh_present[top] = 1'b0;
          sh_count--;
          if (sh_count > 0) begin
            place(0, sh_slot_label[sh_count]);
            bubble_down();
          end
        end
      end
      default: begin
        o.out_label = lab;
        if (!sh_present[lab] || r.entry_key > sh_key[lab]) begin
          o.status = STAT_REFUSED;
          if (sh_present[lab]) begin
            o.out_key  = sh_key[lab];
            o.out_dist = sh_dist[lab];
          end
        end else begin
          sh_key[lab] = r.entry_key;
          sh_dist[lab] = r.entry_dist;
          bubble_up(lab);
          o.out_key  = r.entry_key;
          o.out_dist = r.entry_dist;
        end
      end
    endcase
    o.entry_count = sh_count[8:0];
    return o;
  endfunction

  // monitor and acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    ihd_rsp_t want;
    if (!rst_ni) begin
      took <= 1'b0;
    end else begin
      if (done_o) begin
        if (rsp_q.size() == 0) begin
          $display("result strobe with no transaction outstanding");
          errors++;
        end else begin
          want = rsp_q.pop_front();
          if (rsp_o.status !== want.status)
            report("status", 32'(rsp_o.status), 32'(want.status));
          if (rsp_o.out_label !== want.out_label)
            report("out_label", 32'(rsp_o.out_label), 32'(want.out_label));
          if (rsp_o.out_key !== want.out_key) report("out_key", rsp_o.out_key, want.out_key);
          if (rsp_o.out_dist !== want.out_dist)
            report("out_dist", rsp_o.out_dist, want.out_dist);
          if (rsp_o.entry_count !== want.entry_count)
            report("entry_count", 32'(rsp_o.entry_count), 32'(want.entry_count));
          case (want.status)
            STAT_DONE:  n_done++;
            STAT_EMPTY: n_empty++;
            default:    n_refused++;
          endcase
        end
      end
      if (start_i && !busy_o) begin
        rsp_q.push_back(heap_predict(req_i));
        n_sent++;
      end
      took <= start_i && !busy_o;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && rsp_q.size() != 0)) begin
        req_i <= cmd_q[0].req;
        start_i <= 1'b1;
        gap_left <= cmd_q[0].gap;
        void'(cmd_q.pop_front());
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic int pick_gap(bit busy_stretch);
    int r;
    r = $urandom_range(0, 99);
    if (busy_stretch || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic add(logic [1:0] op, logic [7:0] lab, logic [31:0] k, logic [31:0] d,
                     bit drain = 1'b0, bit busy_stretch = 1'b0);
    heap_cmd_t c;
    c.req.opcode = op;
    c.req.entry_label = lab;
    c.req.entry_key = k;
    c.req.entry_dist = d;
    c.gap = pick_gap(busy_stretch);
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  initial begin
    int         labels[256];
    int         total;
    int         pool;
    int         r;
    bit         stretch;
    logic [7:0] t;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    errors = 0;
    gap_left = 0;
    sh_count = 0;
    foreach (sh_present[j]) sh_present[j] = 1'b0;

    // directed
    add(OP_EXTRACT, 8'd0, 32'd0, 32'd0);
    add(OP_DECREASE, 8'd9, 32'd0, 32'd0);
    add(OP_APPEND, 8'd0, 32'd0, 32'd0);
    add(OP_APPEND, 8'd255, 32'hffff_ffff, 32'hffff_ffff);
    add(OP_APPEND, 8'd255, 32'd5, 32'd5);
    add(OP_APPEND, 8'd17, 32'd100, 32'haaaa_5555);
    add(OP_APPEND, 8'd18, 32'd100, 32'h5555_aaaa);
    add(OP_DECREASE, 8'd17, 32'd200, 32'd1);
    add(OP_DECREASE, 8'd17, 32'd100, 32'd2);
    add(OP_DECREASE, 8'd255, 32'd0, 32'd3);
    add(OP_DECREASE, 8'd18, 32'd50, 32'd4);
    for (int i = 0; i < 6; i++) add(OP_EXTRACT, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
    add(OP_APPEND, 8'd1, 32'd1, 32'd1);
    add(OP_CLEAR, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
    add(OP_EXTRACT, 8'd0, 32'd0, 32'd0);
    add(OP_DECREASE, 8'd1, 32'd0, 32'd0);

    // fill to capacity, overflow, drain
    add(OP_CLEAR, 8'd0, 32'd0, 32'd0, 1'b1);
    foreach (labels[j]) labels[j] = j;
    labels.shuffle();
    foreach (labels[j]) add(OP_APPEND, labels[j][7:0], $urandom_range(0, 40), $urandom());
    add(OP_APPEND, labels[0][7:0], 32'd0, 32'd0);
    for (int i = 0; i < 20; i++)
      add(OP_DECREASE, 8'($urandom()), $urandom_range(0, 30), $urandom());
    for (int i = 0; i < 257; i++)
      add(OP_EXTRACT, 8'($urandom()), $urandom(), $urandom(), 1'b0, i < 60);

    // random phases
    total = cmd_q.size();
    while (total < 1350) begin
      pool = $urandom_range(0, 2) != 0 ? 16 : 256;
      stretch = $urandom_range(0, 3) == 0;
      add(OP_CLEAR, 8'($urandom()), $urandom(), $urandom(), 1'b1, stretch);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        t = 8'($urandom_range(0, pool - 1));
        if (r < 42) add(OP_APPEND, t, pick_key(), $urandom(), 1'b0, stretch);
        else if (r < 70)
          add(OP_EXTRACT, 8'($urandom()), $urandom(), $urandom(), 1'b0, stretch);
        else if (r < 98) add(OP_DECREASE, t, pick_key(), $urandom(), 1'b0, stretch);
        else add(OP_CLEAR, 8'($urandom()), $urandom(), $urandom(), 1'b0, stretch);
      end
      total += 101;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_q.size() == 0 && !start_i && rsp_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (rsp_q.size() != 0) begin
      $display("%0d results never arrived", rsp_q.size());
      errors++;
    end
    $display("%0d transactions: %0d done, %0d empty extracts, %0d refused", n_sent, n_done,
             n_empty, n_refused);
    $display("covered full-heap fill and drain, ties, deep sift-downs (%0d), random gaps",
             n_deep);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
